>>> src/assert_macros.svh
// Assertion macros used by the tile picker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define NUTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tile picker assertion failed");

// Checked on every rising edge of clk_i, also during reset.
`define NUTP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("tile picker assertion failed");

`endif

>>> src/nutp_pkg.sv
// Types and fixed constants of the nearest unloaded tile picker.
package nutp_pkg;

  localparam int COORD_W = 24;
  localparam int PITCH_W = 24;
  localparam int IDX_OUT_W = 4;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 24'd8533;

  typedef struct packed {
    logic valid;
    logic live;
  } nutp_ctl_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } nutp_state_e;

endpackage

>>> src/nutp_dist.sv
// Four-stage pipeline that computes the squared distance from camera to a tile center.
module nutp_dist import nutp_pkg::*; #(
  parameter int SIDE_TILES = 16,
  parameter int TAG_W = 8,
  localparam int RW = $clog2(SIDE_TILES),
  localparam int FW = $clog2(SIDE_TILES + 1),
  localparam int PX_W = PITCH_W + FW,
  localparam int SQ_W = 2 * PX_W,
  localparam int DW = SQ_W + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [PITCH_W-1:0]        pitch_i,
  input  logic signed [COORD_W-1:0] cx_i,
  input  logic signed [COORD_W-1:0] cy_i,
  input  nutp_ctl_t                 in_ctl_i,
  input  logic [RW-1:0]             col_i,
  input  logic [RW-1:0]             row_i,
  input  logic [TAG_W-1:0]          tag_i,
  output nutp_ctl_t                 out_ctl_o,
  output logic [TAG_W-1:0]          out_tag_o,
  output logic [DW-1:0]             dist_o,
  output logic                      busy_o
);

  nutp_ctl_t c1_q, c2_q, c3_q, c4_q;
  logic [TAG_W-1:0] t1_q, t2_q, t3_q, t4_q;
  logic [PX_W-1:0] px_q, py_q;
  logic [PX_W-1:0] ax_q, ay_q;
  logic [SQ_W-1:0] sx_q, sy_q;
  logic [DW-1:0] dist_q;

  logic [FW-1:0] fx, fy;
  logic signed [PX_W:0] cx_ext, cy_ext, dx, dy;

  assign fx = FW'(SIDE_TILES) - FW'(col_i);
  assign fy = FW'(SIDE_TILES) - FW'(row_i);

  assign cx_ext = (PX_W + 1)'(cx_i);
  assign cy_ext = (PX_W + 1)'(cy_i);
  assign dx = cx_ext - signed'({1'b0, px_q});
  assign dy = cy_ext - signed'({1'b0, py_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else begin
      c1_q <= in_ctl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q <= tag_i;
    t2_q <= t1_q;
    t3_q <= t2_q;
    t4_q <= t3_q;
    // Tile center coordinates.
    px_q <= PX_W'(pitch_i) * PX_W'(fx);
    py_q <= PX_W'(pitch_i) * PX_W'(fy);
    // Magnitudes of the offsets; they always fit in PX_W bits.
    ax_q <= dx[PX_W] ? PX_W'(-dx) : dx[PX_W-1:0];
    ay_q <= dy[PX_W] ? PX_W'(-dy) : dy[PX_W-1:0];
    sx_q <= SQ_W'(ax_q) * SQ_W'(ax_q);
    sy_q <= SQ_W'(ay_q) * SQ_W'(ay_q);
    dist_q <= DW'(sx_q) + DW'(sy_q);
  end

  assign out_ctl_o = c4_q;
  assign out_tag_o = t4_q;
  assign dist_o = dist_q;
  assign busy_o = c1_q.valid | c2_q.valid | c3_q.valid | c4_q.valid;

endmodule

>>> src/nearest_unloaded_tile_picker_unit.sv
// Each pick is one full scan of the loaded map, one tile a cycle, through its single
// read port. An update word takes up to PICKS_PER_UPDATE such scans, and no new word
// is accepted until its last pick is emitted.
// An update word that finds every tile loaded is accepted with no result.
// Reset: a clearing pass over every tile zeroes the loaded map;
// no update word is accepted until it ends. tile_pitch resets to 8533.
`include "assert_macros.svh"

module nearest_unloaded_tile_picker_unit import nutp_pkg::*; #(
  parameter int SIDE_TILES = 16,
  parameter int PICKS_PER_UPDATE = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [PITCH_W-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] camera_x_i,
  input  logic signed [COORD_W-1:0] camera_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [IDX_OUT_W-1:0]      tile_row_o,
  output logic [IDX_OUT_W-1:0]      tile_column_o,
  output logic                      last_pick_o
);

  localparam int TILES = SIDE_TILES * SIDE_TILES;
  localparam int AW = $clog2(TILES);
  localparam int RW = $clog2(SIDE_TILES);
  localparam int CW = $clog2(TILES + 1);
  localparam int KW = $clog2(PICKS_PER_UPDATE + 1);
  localparam int TAG_W = AW + 2 * RW;
  localparam int FW = $clog2(SIDE_TILES + 1);
  localparam int DW = 2 * (PITCH_W + FW) + 1;
  localparam int XW = (RW > IDX_OUT_W) ? RW : IDX_OUT_W;

  nutp_state_e state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [RW-1:0] col_q, col_d, row_q, row_d;
  logic [KW-1:0] pick_q, pick_d;
  logic [CW-1:0] loaded_q, loaded_d;
  logic [PITCH_W-1:0] pitch_q;
  logic signed [COORD_W-1:0] cx_q, cy_q;

  logic map_mem [TILES];
  logic rd_bit_q;
  logic rd_valid_q;
  logic [TAG_W-1:0] rd_tag_q;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic mem_wdata;

  nutp_ctl_t din_ctl, dout_ctl;
  logic [TAG_W-1:0] dout_tag;
  logic [DW-1:0] dout_dist;
  logic dist_busy;

  logic found_q;
  logic [DW-1:0] best_dist_q;
  logic [TAG_W-1:0] best_tag_q;
  logic take, start_scan, emit_go, is_last, in_go;
  logic [AW-1:0] best_addr;
  logic [RW-1:0] best_col, best_row;
  logic [XW-1:0] best_col_x, best_row_x;

  logic out_valid_q;
  logic [IDX_OUT_W-1:0] out_row_q, out_col_q;
  logic out_last_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_go = in_valid_i & in_ready_o;

  assign best_addr = best_tag_q[TAG_W-1 -: AW];
  assign best_col = best_tag_q[2*RW-1 -: RW];
  assign best_row = best_tag_q[RW-1:0];
  assign best_col_x = XW'(best_col);
  assign best_row_x = XW'(best_row);

  assign emit_go = (state_q == ST_EMIT) & (~out_valid_q | out_ready_i);
  // The pick is the last one when the quota is met or the grid is now full.
  assign is_last = (pick_q == KW'(PICKS_PER_UPDATE - 1)) || (loaded_q == CW'(TILES - 1));

  always_comb begin
    state_d = state_q;
    addr_d = addr_q;
    col_d = col_q;
    row_d = row_q;
    pick_d = pick_q;
    loaded_d = loaded_q;
    start_scan = 1'b0;
    mem_we = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        addr_d = addr_q + AW'(1);
        if (addr_q == AW'(TILES - 1)) begin
          addr_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_go && (loaded_q != CW'(TILES))) begin
          start_scan = 1'b1;
          pick_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + AW'(1);
        row_d = row_q + RW'(1);
        if (row_q == RW'(SIDE_TILES - 1)) begin
          row_d = '0;
          col_d = col_q + RW'(1);
        end
        if (addr_q == AW'(TILES - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !dist_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          mem_we = 1'b1;
          mem_waddr = best_addr;
          mem_wdata = 1'b1;
          loaded_d = loaded_q + CW'(1);
          pick_d = pick_q + KW'(1);
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            start_scan = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (start_scan) begin
      addr_d = '0;
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q <= '0;
      col_q <= '0;
      row_q <= '0;
      pick_q <= '0;
      loaded_q <= '0;
      pitch_q <= PITCH_RESET;
      rd_valid_q <= 1'b0;
      found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d;
      col_q <= col_d;
      row_q <= row_d;
      pick_q <= pick_d;
      loaded_q <= loaded_d;
      rd_valid_q <= (state_q == ST_SCAN);
      if (cfg_we_i) begin
        pitch_q <= cfg_wdata_i;
      end
      if (start_scan) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Loaded map: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_bit_q <= map_mem[addr_q];
    rd_tag_q <= {addr_q, col_q, row_q};
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      cx_q <= camera_x_i;
      cy_q <= camera_y_i;
    end
    if (take) begin
      best_dist_q <= dout_dist;
      best_tag_q <= dout_tag;
    end
    if (emit_go) begin
      out_row_q <= best_row_x[IDX_OUT_W-1:0];
      out_col_q <= best_col_x[IDX_OUT_W-1:0];
      out_last_q <= is_last;
    end
  end

  assign din_ctl.valid = rd_valid_q;
  assign din_ctl.live = ~rd_bit_q;

  nutp_dist #(
    .SIDE_TILES(SIDE_TILES),
    .TAG_W(TAG_W)
  ) u_dist (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .pitch_i(pitch_q),
    .cx_i(cx_q),
    .cy_i(cy_q),
    .in_ctl_i(din_ctl),
    .col_i(rd_tag_q[2*RW-1 -: RW]),
    .row_i(rd_tag_q[RW-1:0]),
    .tag_i(rd_tag_q),
    .out_ctl_o(dout_ctl),
    .out_tag_o(dout_tag),
    .dist_o(dout_dist),
    .busy_o(dist_busy)
  );

  // Strict less-than keeps the lowest scan index among equal distances.
  assign take = dout_ctl.valid & dout_ctl.live & (~found_q | (dout_dist < best_dist_q));

  assign out_valid_o = out_valid_q;
  assign tile_row_o = out_row_q;
  assign tile_column_o = out_col_q;
  assign last_pick_o = out_last_q;

  `NUTP_ASSERT(a_loaded_bound, loaded_q <= CW'(TILES))
  `NUTP_ASSERT(a_idle_pipe_empty, in_ready_o |-> (!rd_valid_q && !dist_busy))
  `NUTP_ASSERT(a_emit_has_pick, (state_q == ST_EMIT) |-> found_q)
  `NUTP_ASSERT(a_scan_not_full, (state_q == ST_SCAN) |-> (loaded_q < CW'(TILES)))
  `NUTP_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> (state_q == ST_CLEAR || rst_ni))

endmodule

>>> dv/nearest_unloaded_tile_picker_unit_test.sv
// Self-checking testbench for the nearest unloaded tile picker unit.
`timescale 1ns / 100ps

module nearest_unloaded_tile_picker_unit_test import nutp_pkg::*; ();

  localparam int SIDE = 16;
  localparam int TILES = SIDE * SIDE;
  localparam int PICKS = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD = 5000;
  localparam int ITEM_TARGET = 160;
  localparam logic [PITCH_W-1:0] PITCH_MAX = '1;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } camera_word_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] column;
    logic                 last;
  } tile_pick_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [PITCH_W-1:0]        cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] camera_x_i;
  logic signed [COORD_W-1:0] camera_y_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [IDX_OUT_W-1:0]      tile_row_o;
  logic [IDX_OUT_W-1:0]      tile_column_o;
  logic                      last_pick_o;

  nearest_unloaded_tile_picker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .camera_x_i    (camera_x_i),
    .camera_y_i    (camera_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tile_row_o    (tile_row_o),
    .tile_column_o (tile_column_o),
    .last_pick_o   (last_pick_o)
  );

  camera_word_t       camera_queue[$];
  tile_pick_t         pick_queue[$];
  logic               tile_loaded[TILES];
  int                 loaded_total;
  logic [PITCH_W-1:0] pitch_model;

  camera_word_t next_camera;
  tile_pick_t   seen_pick;
  bit           camera_taken;
  bit           pick_taken;
  bit           send_busy;
  bit           steady;
  int           send_wait;
  int           recv_wait;
  int           hold_left;
  int           queued_words;
  int           fail_count;
  int           cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Greedy selection of the nearest unloaded tiles, scan order breaking ties.
  function automatic void predict_nearest_tiles(input logic signed [COORD_W-1:0] cam_x,
                                                input logic signed [COORD_W-1:0] cam_y);
    longint     cx;
    longint     cy;
    longint     dx;
    longint     dy;
    longint     sq_dist;
    longint     best;
    int         best_t;
    int         n;
    bit         found;
    tile_pick_t picks[PICKS];
    tile_pick_t p;
    cx = cam_x;
    cy = cam_y;
    n = 0;
    if (loaded_total >= TILES) return;
    for (int k = 0; k < PICKS; k++) begin
      found = 1'b0;
      best = 0;
      best_t = 0;
      for (int t = 0; t < TILES; t++) begin
        if (!tile_loaded[t]) begin
          dx = cx - longint'(pitch_model) * (SIDE - t / SIDE);
          dy = cy - longint'(pitch_model) * (SIDE - t % SIDE);
          sq_dist = dx * dx + dy * dy;
          if (!found || sq_dist < best) begin
            found = 1'b1;
            best = sq_dist;
            best_t = t;
          end
        end
      end
      if (found) begin
        tile_loaded[best_t] = 1'b1;
        loaded_total++;
        p.row = IDX_OUT_W'(best_t % SIDE);
        p.column = IDX_OUT_W'(best_t / SIDE);
        p.last = 1'b0;
        picks[n] = p;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      p = picks[i];
      p.last = (i == n - 1);
      pick_queue.push_back(p);
    end
  endfunction

  // Mostly lands on or near the grid, so the picks move around with the camera.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int span;
    if (pitch_model != 0 && pitch_model <= 24000 && $urandom_range(0, 3) != 0) begin
      span = int'(pitch_model) * (SIDE + 1);
      return COORD_W'($urandom_range(0, span) - int'(pitch_model / 2));
    end
    return COORD_W'($urandom);
  endfunction

  function automatic logic [PITCH_W-1:0] rand_pitch();
    case ($urandom_range(0, 5))
      0: return PITCH_W'($urandom);
      1: return PITCH_W'($urandom_range(0, 15));
      default: return PITCH_W'($urandom_range(256, 24000));
    endcase
  endfunction

  task automatic write_pitch(input logic [PITCH_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pitch_model = value;
  endtask

  task automatic queue_camera(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
    camera_word_t w;
    w.x = x;
    w.y = y;
    camera_queue.push_back(w);
    queued_words++;
  endtask

  task automatic wait_idle();
    while (camera_queue.size() > 0 || send_busy || pick_queue.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Input side: offers the next camera word after a random gap, or none in steady phases.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (camera_taken) begin
        camera_taken = 1'b0;
        send_busy = 1'b0;
      end
      if (!send_busy && camera_queue.size() > 0) begin
        if (send_wait > 0) begin
          send_wait--;
        end else begin
          next_camera = camera_queue.pop_front();
          camera_x_i <= next_camera.x;
          camera_y_i <= next_camera.y;
          send_busy = 1'b1;
          send_wait = draw_wait();
        end
      end
      in_valid_i <= send_busy;
    end
  end

  // Output side: random stalls per word, plus the long hold-off when requested.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pick_taken) begin
        pick_taken = 1'b0;
        recv_wait = draw_wait();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_nearest_tiles(camera_x_i, camera_y_i);
        camera_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        pick_taken = 1'b1;
        if (pick_queue.size() == 0) begin
          $error("unexpected word: tile_row %0d tile_column %0d last_pick %0b",
                 tile_row_o, tile_column_o, last_pick_o);
          fail_count++;
        end else begin
          seen_pick = pick_queue.pop_front();
          if (tile_row_o !== seen_pick.row) begin
            $error("tile_row: expected %0d, actual %0d", seen_pick.row, tile_row_o);
            fail_count++;
          end
          if (tile_column_o !== seen_pick.column) begin
            $error("tile_column: expected %0d, actual %0d", seen_pick.column, tile_column_o);
            fail_count++;
          end
          if (last_pick_o !== seen_pick.last) begin
            $error("last_pick: expected %0b, actual %0b", seen_pick.last, last_pick_o);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int phase;
    int n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    camera_x_i = '0;
    camera_y_i = '0;
    camera_taken = 1'b0;
    pick_taken = 1'b0;
    send_busy = 1'b0;
    steady = 1'b0;
    send_wait = 0;
    recv_wait = 0;
    hold_left = 0;
    queued_words = 0;
    fail_count = 0;
    cycle_count = 0;
    for (int t = 0; t < TILES; t++) tile_loaded[t] = 1'b0;
    loaded_total = 0;
    pitch_model = PITCH_RESET;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset pitch: corners of the coordinate range, the origin, a tile center, two bit patterns.
    queue_camera(COORD_MIN, COORD_MIN);
    queue_camera(COORD_MAX, COORD_MAX);
    queue_camera(COORD_MIN, COORD_MAX);
    queue_camera(COORD_MAX, COORD_MIN);
    queue_camera('0, '0);
    queue_camera(PITCH_RESET * 8, PITCH_RESET * 8);
    queue_camera(24'sh555555, 24'shAAAAAA);
    queue_camera(24'shAAAAAA, 24'sh555555);
    wait_idle();

    // Zero pitch puts every center at the origin, so scan order alone decides.
    write_pitch('0);
    queue_camera('0, '0);
    queue_camera(COORD_MAX, COORD_MIN);
    queue_camera(rand_coord(), rand_coord());
    wait_idle();

    write_pitch(PITCH_MAX);
    queue_camera(COORD_MAX, COORD_MAX);
    queue_camera(COORD_MIN, COORD_MIN);
    queue_camera('0, '0);
    wait_idle();

    // Camera exactly between two and then four tile centers.
    write_pitch(24'd256);
    queue_camera(24'sd2176, 24'sd2048);
    queue_camera(24'sd2176, 24'sd2176);
    wait_idle();

    phase = 0;
    while (queued_words < ITEM_TARGET) begin
      write_pitch(rand_pitch());
      steady = (phase % 4 == 1);
      if (phase == 2) begin
        @(posedge clk_i);
        hold_left = LONG_HOLD;
      end
      n = (phase == 2) ? 8 : $urandom_range(3, 9);
      repeat (n) queue_camera(rand_coord(), rand_coord());
      wait_idle();
      phase++;
    end

    // Every tile is loaded by now: these words must produce nothing.
    steady = 1'b0;
    write_pitch(rand_pitch());
    repeat (10) queue_camera(rand_coord(), rand_coord());
    wait_idle();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/nutp_pkg.sv
src/nutp_dist.sv
src/nearest_unloaded_tile_picker_unit.sv
dv/nearest_unloaded_tile_picker_unit_test.sv
